// ===== hdl/mf3_pkg.sv =====
// Shared types and constants for the 3x3 median filter.
`default_nettype none
package mf3_pkg;

	localparam int unsigned WIDTH_REG_BITS  = 12;
	localparam int unsigned HEIGHT_REG_BITS = 13;
	localparam int unsigned ROW_BITS        = 12;
	localparam int unsigned COL_BITS        = 11;
	localparam int unsigned VALUE_BITS      = 8;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [WIDTH_REG_BITS-1:0]  FRAME_WIDTH_RST  = 12'd640;
	localparam logic [HEIGHT_REG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [HEIGHT_REG_BITS-1:0] MIN_HEIGHT       = 13'd3;
	localparam logic [HEIGHT_REG_BITS-1:0] MAX_HEIGHT       = 13'd4096;

	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                last;
	} meta_t;

endpackage
`default_nettype wire

// ===== hdl/median_filter_3x3_top.sv =====
// Top level of the 3x3 median filter over a raster grey pixel stream.
// Input channel s_*: one pixel per transfer, s_tdata[7:0] grey level, s_tuser
// high on the first pixel of a frame. Output channel m_*: one transfer per
// interior pixel carrying the median of its 3x3 neighborhood with its row and
// column; m_tlast marks the final interior pixel of the frame. Border pixels
// give no transfer.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 frame width,
// 1 frame height); write only while the stream is idle.
// Throughput: one pixel per cycle while m_tready is high. A single line memory
// holds the two previous rows per column; each pixel reads its column entry and
// writes it back when it leaves stage 1, with forwarding when a new pixel reads
// the entry being written. A result passes the line read, window shift, column
// sort, cross-column select and output register stages before it is on m_*.
// Stalls: each pipeline stage holds while the next is full, so bubbles fill and
// s_tready stays high while a result waits on m_tready until the pipe is full.
// Reset: position returns to row 0, column 0, registers take width 640 and
// height 480, and the pipeline empties; line memory contents are kept.
`default_nettype none
module median_filter_3x3_top #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned PIXEL_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] pixel_value
	input  wire  [0:0]  s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] median_value, [19:8] out_row, [30:20] out_col
	output logic        m_tlast,   // frame_last
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [12:0] cfg_wdata
);

	localparam int unsigned PB = PIXEL_BITS;
	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = (CW + 1 > mf3_pkg::WIDTH_REG_BITS) ?
		CW + 1 : mf3_pkg::WIDTH_REG_BITS;
	localparam int unsigned HB = mf3_pkg::HEIGHT_REG_BITS;
	localparam int unsigned RB = mf3_pkg::ROW_BITS;

	function automatic logic [PB-1:0] max2(input logic [PB-1:0] a, input logic [PB-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [PB-1:0] min2(input logic [PB-1:0] a, input logic [PB-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, input logic [PB-1:0] b,
			input logic [PB-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// packed {max, mid, min}
	function automatic logic [3*PB-1:0] sort3(input logic [PB-1:0] a, input logic [PB-1:0] b,
			input logic [PB-1:0] c);
		return {max2(max2(a, b), c), med3(a, b, c), min2(min2(a, b), c)};
	endfunction

	// configuration
	logic [mf3_pkg::WIDTH_REG_BITS-1:0] frame_width_q;
	logic [HB-1:0]                      frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= mf3_pkg::FRAME_WIDTH_RST;
			frame_height_q <= mf3_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mf3_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[mf3_pkg::WIDTH_REG_BITS-1:0];
				mf3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [WW-1:0] width_c;
	logic [HB-1:0] height_c;

	always_comb begin
		if (WW'(frame_width_q) < WW'(3)) begin
			width_c = WW'(3);
		end else if (WW'(frame_width_q) > WW'(MAX_WIDTH)) begin
			width_c = WW'(MAX_WIDTH);
		end else begin
			width_c = WW'(frame_width_q);
		end
		if (frame_height_q < mf3_pkg::MIN_HEIGHT) begin
			height_c = mf3_pkg::MIN_HEIGHT;
		end else if (frame_height_q > mf3_pkg::MAX_HEIGHT) begin
			height_c = mf3_pkg::MAX_HEIGHT;
		end else begin
			height_c = frame_height_q;
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4;
	logic accept;

	assign rdy4     = !v_s5 || m_tready;
	assign rdy3     = !v_s4 || rdy4;
	assign rdy2     = !v_s3 || rdy3;
	assign rdy1     = !v_s2 || rdy2;
	assign s_tready = !v_s1 || rdy1;
	assign accept   = s_tvalid && s_tready;

	// position tracking
	logic [CW-1:0] col_q;
	logic [RB-1:0] row_q;
	logic [WW-1:0] col_a, col_n;
	logic [HB-1:0] row_a, row_b, row_n;
	logic [CW-1:0] c0;
	logic [RB-1:0] r0;
	logic [RB-1:0] r_next;
	logic [CW-1:0] c_next;

	always_comb begin
		if (s_tuser[0]) begin
			col_a = '0;
			row_a = '0;
		end else begin
			col_a = WW'(col_q);
			row_a = HB'(row_q);
		end
		if (col_a >= width_c) begin
			col_a = '0;
			row_b = row_a + HB'(1);
		end else begin
			row_b = row_a;
		end
		if (row_b >= height_c) begin
			row_b = '0;
		end
		c0 = col_a[CW-1:0];
		r0 = row_b[RB-1:0];

		col_n = WW'(c0) + WW'(1);
		row_n = HB'(r0);
		if (col_n >= width_c) begin
			c_next = '0;
			row_n  = HB'(r0) + HB'(1);
			if (row_n >= height_c) begin
				row_n = '0;
			end
		end else begin
			c_next = col_n[CW-1:0];
		end
		r_next = row_n[RB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= c_next;
			row_q <= r_next;
		end
	end

	// stage 1: line memory read, write back on advance
	logic [CW-1:0]     c_s1;
	logic [RB-1:0]     r_s1;
	logic [PB-1:0]     pix_s1;
	logic              fwd_s1;
	logic [2*PB-1:0]   fwd_data_s1;
	logic [2*PB-1:0]   ram_rdata;
	logic [2*PB-1:0]   line_s1;
	logic [2*PB-1:0]   ram_wdata;
	logic              ram_we;
	logic [PB-1:0]     above, above2;
	logic              emit_s1;
	mf3_pkg::meta_t    meta_s1;

	assign line_s1   = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign above     = line_s1[2*PB-1:PB];
	assign above2    = line_s1[PB-1:0];
	assign ram_we    = v_s1 && rdy1;
	assign ram_wdata = {pix_s1, above};
	assign emit_s1   = (r_s1 >= RB'(2)) && (c_s1 >= CW'(2));

	always_comb begin
		meta_s1.row  = mf3_pkg::ROW_BITS'(r_s1 - RB'(1));
		meta_s1.col  = mf3_pkg::COL_BITS'(c_s1 - CW'(1));
		meta_s1.last = (HB'(r_s1) == height_c - HB'(1)) && (WW'(c_s1) == width_c - WW'(1));
	end

	mf3_ram #(
		.WIDTH(2 * PB),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(c_s1),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(c0),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1        <= c0;
			r_s1        <= r0;
			pix_s1      <= PB'(s_tdata);
			fwd_s1      <= ram_we && (c_s1 == c0);
			fwd_data_s1 <= ram_wdata;
		end
	end

	// stage 2: window shift
	logic [PB-1:0]  win_q [9];
	mf3_pkg::meta_t meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy1) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= above2;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= above;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= pix_s1;
			meta_s2  <= meta_s1;
		end
	end

	// stage 3: sort each column
	logic [3*PB-1:0] col_sort_s3 [3];
	mf3_pkg::meta_t  meta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy2) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int j = 0; j < 3; j++) begin
				col_sort_s3[j] <= sort3(win_q[j], win_q[3+j], win_q[6+j]);
			end
			meta_s3 <= meta_s2;
		end
	end

	// stage 4: max of mins, median of mids, min of maxes
	logic [PB-1:0]  lo_s4, mid_s4, hi_s4;
	mf3_pkg::meta_t meta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy3) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			lo_s4   <= max2(max2(col_sort_s3[0][PB-1:0], col_sort_s3[1][PB-1:0]),
				col_sort_s3[2][PB-1:0]);
			mid_s4  <= med3(col_sort_s3[0][2*PB-1:PB], col_sort_s3[1][2*PB-1:PB],
				col_sort_s3[2][2*PB-1:PB]);
			hi_s4   <= min2(min2(col_sort_s3[0][3*PB-1:2*PB], col_sort_s3[1][3*PB-1:2*PB]),
				col_sort_s3[2][3*PB-1:2*PB]);
			meta_s4 <= meta_s3;
		end
	end

	// stage 5: output register
	logic [PB-1:0]  med_s5;
	mf3_pkg::meta_t meta_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy4) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			med_s5  <= med3(lo_s4, mid_s4, hi_s4);
			meta_s5 <= meta_s4;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {1'b0, meta_s5.col, meta_s5.row, mf3_pkg::VALUE_BITS'(med_s5)};
	assign m_tlast  = meta_s5.last;

	// checks
	a_fwd_on_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && accept && (c_s1 == c0)) |=> fwd_s1)
		else $error("line memory read of entry being written not forwarded");

	a_median_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && rdy4) |=> ((med_s5 >= min2($past(lo_s4), $past(hi_s4)))
			&& (med_s5 <= max2($past(lo_s4), $past(hi_s4)))))
		else $error("median outside column bounds");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((meta_s5.row != '0) && (meta_s5.col != '0)))
		else $error("result issued for a border pixel");

endmodule
`default_nettype wire

// ===== hdl/mf3_ram.sv =====
// Simple dual-port RAM with registered, read-first output.
`default_nettype none
module mf3_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2048
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the 3x3 median filter against a stream predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_LEN    = 2048;
	localparam int unsigned MIN_WIDTH   = 3;
	localparam int unsigned WIN_SIZE    = 9;
	localparam int unsigned WIN_CENTER  = 4;
	localparam int unsigned ROW_LSB     = mf3_pkg::VALUE_BITS;
	localparam int unsigned COL_LSB     = mf3_pkg::VALUE_BITS + mf3_pkg::ROW_BITS;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned HOLD_AFTER  = 20;
	localparam int unsigned FILL_WIDTH  = 16;
	localparam int unsigned RAND_ITEMS  = 450;

	typedef struct packed {
		logic [mf3_pkg::VALUE_BITS-1:0] value;
		logic                           sof;
	} pixel_t;

	typedef struct packed {
		logic [mf3_pkg::VALUE_BITS-1:0] median;
		mf3_pkg::meta_t                 meta;
	} median_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [12:0] cfg_wdata = '0;

	pixel_t  pixel_q[$];
	median_t median_q[$];

	logic [mf3_pkg::VALUE_BITS-1:0] line_newer [LINE_LEN];
	logic [mf3_pkg::VALUE_BITS-1:0] line_older [LINE_LEN];
	logic [mf3_pkg::VALUE_BITS-1:0] win [WIN_SIZE];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [mf3_pkg::WIDTH_REG_BITS-1:0]  width_setting  = mf3_pkg::FRAME_WIDTH_RST;
	logic [mf3_pkg::HEIGHT_REG_BITS-1:0] height_setting = mf3_pkg::FRAME_HEIGHT_RST;

	int unsigned tx_gap   = 0;
	bit          tx_burst = 1'b0;
	int unsigned rx_stall = 0;
	bit          rx_burst = 1'b0;
	int unsigned long_hold = 0;
	bit          hold_done = 1'b0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;

	median_filter_3x3_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned pick_gap(input bit burst);
		int unsigned r;
		r = $urandom_range(99);
		if (burst || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [mf3_pkg::VALUE_BITS-1:0] noisy_pixel();
		int unsigned r;
		logic [mf3_pkg::VALUE_BITS-1:0] v;
		r = $urandom_range(99);
		v = mf3_pkg::VALUE_BITS'($urandom_range(255));
		if (r < 8)
			v = '0;
		else if (r < 16)
			v = '1;
		else if (r < 36)
			v = mf3_pkg::VALUE_BITS'($urandom_range(130, 126));
		return v;
	endfunction

	// Filter one accepted pixel and queue the median it completes, if any.
	task automatic filter_pixel(input logic [mf3_pkg::VALUE_BITS-1:0] pix, input logic sof);
		int unsigned w, h, c, r, i, j;
		logic [mf3_pkg::VALUE_BITS-1:0] up1, up2, v;
		logic [mf3_pkg::VALUE_BITS-1:0] s [WIN_SIZE];
		median_t res;
		w = 32'(width_setting);
		if (w < MIN_WIDTH)
			w = MIN_WIDTH;
		else if (w > LINE_LEN)
			w = LINE_LEN;
		h = 32'(height_setting);
		if (h < 32'(mf3_pkg::MIN_HEIGHT))
			h = 32'(mf3_pkg::MIN_HEIGHT);
		else if (h > 32'(mf3_pkg::MAX_HEIGHT))
			h = 32'(mf3_pkg::MAX_HEIGHT);
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;
		up2 = line_older[c];
		up1 = line_newer[c];
		line_older[c] = up1;
		line_newer[c] = pix;
		for (i = 0; i < WIN_SIZE; i += 3) begin
			win[i]     = win[i + 1];
			win[i + 1] = win[i + 2];
		end
		win[2] = up2;
		win[5] = up1;
		win[8] = pix;
		if (r >= 2 && c >= 2) begin
			for (i = 0; i < WIN_SIZE; i++)
				s[i] = win[i];
			for (i = 1; i < WIN_SIZE; i++) begin
				v = s[i];
				j = i;
				while (j > 0 && s[j - 1] > v) begin
					s[j] = s[j - 1];
					j--;
				end
				s[j] = v;
			end
			res.median    = s[WIN_CENTER];
			res.meta.row  = mf3_pkg::ROW_BITS'(r - 1);
			res.meta.col  = mf3_pkg::COL_BITS'(c - 1);
			res.meta.last = (r == h - 1) && (c == w - 1);
			median_q.push_back(res);
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			tx_gap   <= 0;
			tx_burst <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				filter_pixel(s_tdata, s_tuser[0]);
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					s_tvalid <= 1'b0;
					tx_gap   <= tx_gap - 1;
				end else if (pixel_q.size() != 0) begin
					nxt = pixel_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.value;
					s_tuser  <= nxt.sof;
					if ($urandom_range(63) == 0)
						tx_burst <= !tx_burst;
					tx_gap <= pick_gap(tx_burst);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		median_t want;
		if (!arst_n) begin
			m_tready     <= 1'b0;
			rx_stall     <= 0;
			rx_burst     <= 1'b0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if ($urandom_range(63) == 0)
					rx_burst <= !rx_burst;
				if (median_q.size() == 0) begin
					$error("unexpected result: median_value %0d out_row %0d out_col %0d",
						m_tdata[mf3_pkg::VALUE_BITS-1:0], m_tdata[ROW_LSB +: mf3_pkg::ROW_BITS],
						m_tdata[COL_LSB +: mf3_pkg::COL_BITS]);
					mismatch_count++;
				end else begin
					want = median_q.pop_front();
					if (m_tdata[mf3_pkg::VALUE_BITS-1:0] !== want.median) begin
						$error("median_value: expected %0d, got %0d", want.median,
							m_tdata[mf3_pkg::VALUE_BITS-1:0]);
						mismatch_count++;
					end
					if (m_tdata[ROW_LSB +: mf3_pkg::ROW_BITS] !== want.meta.row) begin
						$error("out_row: expected %0d, got %0d", want.meta.row,
							m_tdata[ROW_LSB +: mf3_pkg::ROW_BITS]);
						mismatch_count++;
					end
					if (m_tdata[COL_LSB +: mf3_pkg::COL_BITS] !== want.meta.col) begin
						$error("out_col: expected %0d, got %0d", want.meta.col,
							m_tdata[COL_LSB +: mf3_pkg::COL_BITS]);
						mismatch_count++;
					end
					if (m_tlast !== want.meta.last) begin
						$error("frame_last: expected %0d, got %0d", want.meta.last, m_tlast);
						mismatch_count++;
					end
				end
			end
			if (long_hold != 0) begin
				m_tready <= 1'b0;
			end else if (rx_stall != 0) begin
				m_tready <= 1'b0;
				rx_stall <= rx_stall - 1;
			end else begin
				m_tready <= 1'b1;
				if (!rx_burst && $urandom_range(99) < 20)
					rx_stall <= pick_gap(1'b0);
			end
		end
	end

	// Hold off the output once while input is pending, long enough to back up the pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 0;
			hold_done <= 1'b0;
		end else if (long_hold != 0) begin
			long_hold <= long_hold - 1;
		end else if (!hold_done && results_seen >= HOLD_AFTER && pixel_q.size() > 16) begin
			long_hold <= LONG_HOLD;
			hold_done <= 1'b1;
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mf3_pkg::REG_FRAME_WIDTH)
			width_setting = val[mf3_pkg::WIDTH_REG_BITS-1:0];
		else
			height_setting = val;
	endtask

	task automatic push_pixel(input logic [mf3_pkg::VALUE_BITS-1:0] v, input bit sof);
		pixel_t p;
		p.value = v;
		p.sof   = sof;
		pixel_q.push_back(p);
	endtask

	task automatic push_run(input int unsigned count, input bit sof_first);
		int unsigned i;
		for (i = 0; i < count; i++)
			push_pixel(noisy_pixel(), sof_first && i == 0);
	endtask

	task automatic wait_idle();
		while (pixel_q.size() != 0 || s_tvalid || median_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [mf3_pkg::VALUE_BITS-1:0] scrambled [WIN_SIZE];
		int unsigned i, k, n, cur_w, cur_h, nframes, rand_items;
		logic [12:0] val;
		scrambled = '{8'd9, 8'd1, 8'd8, 8'd2, 8'd7, 8'd3, 8'd6, 8'd4, 8'd5};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size: part of the first row
		push_run(64, 1'b1);
		wait_idle();

		// fill both line halves up to the widest random width
		write_reg(mf3_pkg::REG_FRAME_WIDTH, 13'(FILL_WIDTH));
		write_reg(mf3_pkg::REG_FRAME_HEIGHT, 13'd3);
		push_run(3 * FILL_WIDTH, 1'b1);
		wait_idle();

		// smallest frame: ordered median, wrap without frame start, restart mid-frame
		write_reg(mf3_pkg::REG_FRAME_WIDTH, 13'd2);
		write_reg(mf3_pkg::REG_FRAME_HEIGHT, 13'd0);
		for (i = 0; i < WIN_SIZE; i++)
			push_pixel(scrambled[i], i == 0);
		for (i = 0; i < WIN_SIZE; i++)
			push_pixel(8'hFF, 1'b0);
		push_pixel(8'h00, 1'b1);
		push_pixel(8'h00, 1'b0);
		for (i = 0; i < WIN_SIZE; i++)
			push_pixel((i % 2) ? 8'hFF : 8'h00, i == 0);
		wait_idle();

		// height above range
		write_reg(mf3_pkg::REG_FRAME_WIDTH, 13'd3);
		write_reg(mf3_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
		push_run(60, 1'b1);
		wait_idle();

		cur_w = 3;
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			if ($urandom_range(3) != 0) begin
				k = $urandom_range(99);
				if (k < 70)
					val = 13'($urandom_range(10, 3));
				else if (k < 85)
					val = 13'($urandom_range(FILL_WIDTH, 11));
				else
					val = 13'($urandom_range(2, 0));
				write_reg(mf3_pkg::REG_FRAME_WIDTH, val);
				cur_w = (val < 13'(MIN_WIDTH)) ? MIN_WIDTH : 32'(val);
			end
			k = $urandom_range(99);
			if (k < 80)
				val = 13'($urandom_range(6, 3));
			else if (k < 90)
				val = 13'($urandom_range(2, 0));
			else
				val = 13'($urandom_range(12, 7));
			write_reg(mf3_pkg::REG_FRAME_HEIGHT, val);
			cur_h = (val < mf3_pkg::MIN_HEIGHT) ? 32'(mf3_pkg::MIN_HEIGHT) : 32'(val);

			nframes = $urandom_range(3, 1);
			for (i = 0; i < nframes && rand_items < RAND_ITEMS; i++) begin
				k = $urandom_range(99);
				if (k < 60) begin
					n = cur_w * cur_h;
					push_run(n, 1'b1);
				end else if (k < 72) begin
					n = cur_w * cur_h;
					push_run(n, 1'b0);
				end else if (k < 84) begin
					n = $urandom_range(cur_w * cur_h - 1, 1);
					push_run(n, 1'b1);
				end else if (k < 94) begin
					n = $urandom_range(20, 1);
					push_run(n, $urandom_range(9) == 0);
				end else begin
					n = cur_w * cur_h + $urandom_range(cur_w * cur_h, 1);
					push_run(n, 1'b1);
				end
				rand_items += n;
			end
			wait_idle();
		end

		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && median_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
